// ===== hw/rtl/rial_pkg.sv =====
// Package for the integer ALU with register file: command codes and field widths.
// No dependencies.
package rial_pkg;
   typedef enum logic [4:0] {
      CMD_ADD   = 5'd0,  CMD_ADDI  = 5'd1,  CMD_ADDIU = 5'd2,  CMD_ADDU = 5'd3,
      CMD_SUB   = 5'd4,  CMD_SUBU  = 5'd5,  CMD_DIV   = 5'd6,  CMD_DIVU = 5'd7,
      CMD_MULT  = 5'd8,  CMD_MULTU = 5'd9,  CMD_SLL   = 5'd10, CMD_SLLV = 5'd11,
      CMD_SRA   = 5'd12, CMD_SRAV  = 5'd13, CMD_SRL   = 5'd14, CMD_SRLV = 5'd15,
      CMD_AND   = 5'd16, CMD_ANDI  = 5'd17, CMD_NOR   = 5'd18, CMD_OR   = 5'd19,
      CMD_ORI   = 5'd20, CMD_XOR   = 5'd21, CMD_XORI  = 5'd22, CMD_SLT  = 5'd23,
      CMD_SLTI  = 5'd24, CMD_SLTIU = 5'd25, CMD_SLTU  = 5'd26
   } cmd_type;

   localparam int IDX_W  = 5;
   localparam int WORD_W = 32;
endpackage

// ===== hw/rtl/rial_ram.sv =====
// Generic single-write, dual-read synchronous RAM with registered read outputs.
// No dependencies.
module rial_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

// ===== hw/rtl/risc_integer_alu_regfile.sv =====
// Top level of the integer ALU with register file; uses rial_pkg and rial_ram.
// Holds the instruction sequencer, the shift-add multiplier and restoring divider.
//
// Usage:
//   One instruction beat enters on req_ (command, register numbers, shift amount,
//   immediate); one result beat leaves on rsp_ per instruction. The general
//   registers sit in a two-read-port RAM; HI and LO are flip-flops.
//   After reset the block sweeps the RAM clearing it, one entry per cycle,
//   with req_tready low.
//   A simple ALU instruction passes through S_READ (RAM read) and S_EXEC (execute)
//   before rsp_tvalid rises. Multiply and divide iterate one bit per cycle in
//   S_ITER, then pass S_DONE; a divide by zero skips both and answers from S_EXEC.
//   The RAM read port and the one-bit-per-cycle mult/div unit set this timing.
//   The block handles one instruction at a time; req_tready rises again once the
//   result beat is taken. A stall on rsp_tready holds the result beat unchanged.
//   Register 0 and numbers at or above REG_COUNT read as zero and are never written.
module risc_integer_alu_regfile
   import rial_pkg::*;
#(
   parameter int REG_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] command, [9:5] rs_index, [14:10] rt_index, [19:15] rd_index,
   // [24:20] shift_amount, [40:25] immediate, [47:41] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] reg_written, [5:1] written_index, [37:6] written_value,
   // [69:38] hi_value, [101:70] lo_value, [102] overflow_trap, [103] zero
   output logic [103:0] rsp_tdata
);
   localparam int AW = $clog2(REG_COUNT);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_ITER, S_DONE, S_RESP} state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [4:0] cmd_ff, rs_ff, rt_ff, rd_ff, sa_ff;
   logic [15:0] imm_ff;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [31:0] acc_ff, acc_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [103:0] rsp_ff, rsp_in;

   logic [31:0] ram_a, ram_b, a, b, si, zi, r;
   logic        wr, trap, is_md;
   logic [4:0]  dest;
   logic        we;
   logic [AW-1:0] waddr;
   logic [31:0] wdata;

   // Read from the captured register numbers so the data stays put while
   // the next beat waits on req_tdata.
   rial_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_regs (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr_a(rs_ff[AW-1:0]), .rd_addr_b(rt_ff[AW-1:0]),
      .rd_data_a(ram_a), .rd_data_b(ram_b)
   );

   // Out-of-range or zero registers read as zero.
   assign a  = (rs_ff == '0 || {27'd0, rs_ff} >= REG_COUNT) ? '0 : ram_a;
   assign b  = (rt_ff == '0 || {27'd0, rt_ff} >= REG_COUNT) ? '0 : ram_b;
   assign si = {{16{imm_ff[15]}}, imm_ff};
   assign zi = {16'd0, imm_ff};

   always_comb begin
      logic [31:0] sum, dif;
      sum = a + ((cmd_ff == CMD_ADDI || cmd_ff == CMD_ADDIU) ? si : b);
      dif = a - b;
      r = '0; wr = 1'b1; trap = 1'b0; dest = rd_ff; is_md = 1'b0;
      case (cmd_ff)
         CMD_ADD:   begin r = sum; trap = (a[31] ~^ b[31]) & (a[31] ^ sum[31]); end
         CMD_ADDI:  begin r = sum; dest = rt_ff; trap = (a[31] ~^ si[31]) & (a[31] ^ sum[31]); end
         CMD_ADDIU: begin r = sum; dest = rt_ff; end
         CMD_ADDU:  r = sum;
         CMD_SUB:   begin r = dif; trap = (a[31] ^ b[31]) & (a[31] ^ dif[31]); end
         CMD_SUBU:  r = dif;
         CMD_DIV, CMD_DIVU, CMD_MULT, CMD_MULTU: begin wr = 1'b0; is_md = 1'b1; end
         CMD_SLL:   r = b << sa_ff;
         CMD_SLLV:  r = b << a[4:0];
         CMD_SRA:   r = $unsigned($signed(b) >>> sa_ff);
         CMD_SRAV:  r = $unsigned($signed(b) >>> a[4:0]);
         CMD_SRL:   r = b >> sa_ff;
         CMD_SRLV:  r = b >> a[4:0];
         CMD_AND:   r = a & b;
         CMD_ANDI:  begin r = a & zi; dest = rt_ff; end
         CMD_NOR:   r = ~(a | b);
         CMD_OR:    r = a | b;
         CMD_ORI:   begin r = a | zi; dest = rt_ff; end
         CMD_XOR:   r = a ^ b;
         CMD_XORI:  begin r = a ^ zi; dest = rt_ff; end
         CMD_SLT:   r = {31'd0, $signed(a) < $signed(b)};
         CMD_SLTI:  begin r = {31'd0, $signed(a) < $signed(si)}; dest = rt_ff; end
         CMD_SLTIU: begin r = {31'd0, a < si}; dest = rt_ff; end
         CMD_SLTU:  r = {31'd0, a < b};
         default:   wr = 1'b0;
      endcase
      if (trap || dest == '0 || {27'd0, dest} >= REG_COUNT) wr = 1'b0;
   end

   always_comb begin
      logic [32:0] trial;
      logic [32:0] psum;
      logic        sdiv;
      state_in = state_ff; clr_in = clr_ff;
      hi_in = hi_ff; lo_in = lo_ff;
      acc_in = acc_ff; quo_in = quo_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; rsp_in = rsp_ff;
      we = 1'b0; waddr = clr_ff; wdata = '0;
      trial = '0; psum = '0;
      sdiv = (cmd_ff == CMD_DIV || cmd_ff == CMD_MULT);
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(REG_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req_tvalid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            if (is_md) begin
               // Load magnitudes; quo holds multiplier or dividend bits.
               neg_q_in = sdiv & (a[31] ^ b[31]);
               neg_r_in = sdiv & a[31];
               quo_in   = (sdiv && a[31]) ? -a : a;
               dvs_in   = (sdiv && b[31]) ? -b : b;
               acc_in   = '0;
               cnt_in   = 6'd32;
               if ((cmd_ff == CMD_DIV || cmd_ff == CMD_DIVU) && b == '0) begin
                  rsp_in = {1'b0, 1'b0, lo_ff, hi_ff, 32'd0, 5'd0, 1'b0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_ITER;
               end
            end else begin
               we = wr; waddr = dest[AW-1:0]; wdata = r;
               rsp_in = {1'b0, trap, lo_ff, hi_ff, wr ? r : 32'd0,
                         wr ? dest : 5'd0, wr};
               state_in = S_RESP;
            end
         end
         S_ITER: begin
            if (cmd_ff == CMD_MULT || cmd_ff == CMD_MULTU) begin
               // Shift-add: acc:quo is the product, multiplier bits shift out of quo.
               psum = {1'b0, acc_ff} + (quo_ff[0] ? {1'b0, dvs_ff} : 33'd0);
               acc_in = psum[32:1];
               quo_in = {psum[0], quo_ff[31:1]};
            end else begin
               // Restoring division: acc is the partial remainder.
               trial = {acc_ff, quo_ff[31]} - {1'b0, dvs_ff};
               if (!trial[32]) begin
                  acc_in = trial[31:0];
                  quo_in = {quo_ff[30:0], 1'b1};
               end else begin
                  acc_in = {acc_ff[30:0], quo_ff[31]};
                  quo_in = {quo_ff[30:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd_ff == CMD_MULT || cmd_ff == CMD_MULTU) begin
               {hi_in, lo_in} = neg_q_ff ? -{acc_ff, quo_ff} : {acc_ff, quo_ff};
            end else begin
               lo_in = neg_q_ff ? -quo_ff : quo_ff;
               hi_in = neg_r_ff ? -acc_ff : acc_ff;
            end
            rsp_in = {1'b0, 1'b0, lo_in, hi_in, 32'd0, 5'd0, 1'b0};
            state_in = S_RESP;
         end
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
      // Payload: capture the instruction on the accepted beat, hold otherwise.
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tdata[4:0];
         rs_ff  <= req_tdata[9:5];
         rt_ff  <= req_tdata[14:10];
         rd_ff  <= req_tdata[19:15];
         sa_ff  <= req_tdata[24:20];
         imm_ff <= req_tdata[40:25];
      end
      acc_ff <= acc_in; quo_ff <= quo_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; rsp_ff <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result beat changed under stall");
   a_trap_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[102] && rsp_tdata[0]))
      else $error("trap with register write");
   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[5:1] != 5'd0)
      else $error("register zero reported written");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("accept while result pending");
endmodule
